// ===== src/ipid_pkg.sv =====
// ----------------------------------------------------------------------------
// ipid_pkg: shared types and constants of the incremental PID unit
// Widths, reset gains, register indexes, opcodes and the controller state.
// ----------------------------------------------------------------------------
`default_nettype none

package ipid_pkg;

    localparam int FRACTION_BITS = 8;
    localparam int TEMP_BITS     = 10;
    localparam int GAIN_BITS     = 15;
    localparam int ACC_BITS      = 32;
    localparam int OUT_BITS      = 16;
    localparam int CFG_ADDR_BITS = 2;

    // Widest intermediate: gain * accumulator plus gain * error.
    localparam int DIRECT_BITS   = GAIN_BITS + ACC_BITS + 2;

    localparam int ARM_THRESHOLD = 30;
    localparam int SEED_LIMIT    = 1000;
    localparam int ROUND_HALF    = 1 << (FRACTION_BITS - 1);

    localparam logic [GAIN_BITS-1:0] GAIN_P_RESET = GAIN_BITS'(768);
    localparam logic [GAIN_BITS-1:0] GAIN_I_RESET = GAIN_BITS'(30);
    localparam logic [GAIN_BITS-1:0] GAIN_D_RESET = GAIN_BITS'(196);

    localparam logic [CFG_ADDR_BITS-1:0] REG_GAIN_P = CFG_ADDR_BITS'(0);
    localparam logic [CFG_ADDR_BITS-1:0] REG_GAIN_I = CFG_ADDR_BITS'(1);
    localparam logic [CFG_ADDR_BITS-1:0] REG_GAIN_D = CFG_ADDR_BITS'(2);

    typedef enum logic {
        OP_STEP    = 1'b0,
        OP_RESTART = 1'b1
    } opcode_t;

    typedef logic [TEMP_BITS-1:0]       temp_t;
    typedef logic [GAIN_BITS-1:0]       gain_t;
    typedef logic signed [ACC_BITS-1:0] acc_t;
    typedef logic signed [OUT_BITS-1:0] power_t;

    typedef struct packed {
        gain_t gain_p;
        gain_t gain_i;
        gain_t gain_d;
    } pid_gains_t;

    typedef struct packed {
        temp_t older_temp;
        temp_t last_temp;
        logic  armed_flag;
        acc_t  error_sum;
        acc_t  power_acc;
    } pid_state_t;

endpackage

`default_nettype wire

// ===== src/ipid_step.sv =====
// ----------------------------------------------------------------------------
// ipid_step: one controller update
// Combinational next state and rounded output for one step or restart item.
// ----------------------------------------------------------------------------
`default_nettype none

module ipid_step (
    input  wire ipid_pkg::opcode_t    opcode,
    input  wire ipid_pkg::temp_t      setpoint,
    input  wire ipid_pkg::temp_t      measured,
    input  wire ipid_pkg::pid_gains_t gains,
    input  wire ipid_pkg::pid_state_t state_cur,
    output ipid_pkg::pid_state_t      state_nxt,
    output ipid_pkg::power_t          drive_power
);

    // Clamp a wide signed value to the accumulator range.
    function automatic ipid_pkg::acc_t sat_to_acc(
        input logic signed [ipid_pkg::DIRECT_BITS-1:0] v
    );
        logic [ipid_pkg::DIRECT_BITS-ipid_pkg::ACC_BITS:0] hi;
        ipid_pkg::acc_t res;
        hi = v[ipid_pkg::DIRECT_BITS-1:ipid_pkg::ACC_BITS-1];
        if ((&hi) || !(|hi)) begin
            res = v[ipid_pkg::ACC_BITS-1:0];
        end else if (v[ipid_pkg::DIRECT_BITS-1]) begin
            res = {1'b1, {(ipid_pkg::ACC_BITS-1){1'b0}}};
        end else begin
            res = {1'b0, {(ipid_pkg::ACC_BITS-1){1'b1}}};
        end
        return res;
    endfunction

    // Clamp the shifted accumulator to the output range.
    function automatic ipid_pkg::power_t sat_to_out(
        input logic signed [ipid_pkg::ACC_BITS:0] v
    );
        logic [ipid_pkg::ACC_BITS-ipid_pkg::OUT_BITS+1:0] hi;
        ipid_pkg::power_t res;
        hi = v[ipid_pkg::ACC_BITS:ipid_pkg::OUT_BITS-1];
        if ((&hi) || !(|hi)) begin
            res = v[ipid_pkg::OUT_BITS-1:0];
        end else if (v[ipid_pkg::ACC_BITS]) begin
            res = {1'b1, {(ipid_pkg::OUT_BITS-1){1'b0}}};
        end else begin
            res = {1'b0, {(ipid_pkg::OUT_BITS-1){1'b1}}};
        end
        return res;
    endfunction

    localparam int TB = ipid_pkg::TEMP_BITS;
    localparam int GB = ipid_pkg::GAIN_BITS;
    localparam int AB = ipid_pkg::ACC_BITS;
    localparam int DB = ipid_pkg::DIRECT_BITS;

    logic signed [GB:0]        gp_s, gi_s, gd_s;
    logic signed [TB:0]        err, dl;
    logic signed [TB+1:0]      dd;
    logic                      history, arm_now, armed_n;
    ipid_pkg::acc_t            sum_base, sum_sat, power_n;
    logic signed [GB+TB+1:0]   prod_pe, prod_pl, prod_ie;
    logic signed [GB+TB+2:0]   prod_dd;
    logic signed [GB+AB:0]     prod_is;
    logic signed [DB-1:0]      sum_wide, direct_wide, vel_wide;
    logic signed [AB:0]        rnd, shifted;
    logic                      seed_ok;

    always_comb begin
        gp_s = $signed({1'b0, gains.gain_p});
        gi_s = $signed({1'b0, gains.gain_i});
        gd_s = $signed({1'b0, gains.gain_d});

        err = $signed({1'b0, setpoint}) - $signed({1'b0, measured});
        dl  = $signed({1'b0, state_cur.last_temp}) - $signed({1'b0, measured});
        dd  = $signed({2'b00, state_cur.older_temp}) + $signed({2'b00, measured})
            - $signed({1'b0, state_cur.last_temp, 1'b0});

        history = (state_cur.older_temp != '0);
        arm_now = !history && !state_cur.armed_flag
                  && (err < $signed((TB+1)'(ipid_pkg::ARM_THRESHOLD)));
        armed_n = state_cur.armed_flag | arm_now;

        // Direct form: integrate, then gain the error and the sum.
        sum_base    = arm_now ? '0 : state_cur.error_sum;
        sum_wide    = DB'(sum_base) + DB'(err);
        sum_sat     = sat_to_acc(sum_wide);
        prod_pe     = gp_s * err;
        prod_is     = gi_s * sum_sat;
        direct_wide = DB'(prod_pe) + DB'(prod_is);

        // Velocity form: accumulate the three difference terms.
        prod_pl  = gp_s * dl;
        prod_ie  = gi_s * err;
        prod_dd  = gd_s * dd;
        vel_wide = DB'(state_cur.power_acc) + DB'(prod_pl) + DB'(prod_ie)
                 + DB'(prod_dd);

        power_n = history ? sat_to_acc(vel_wide) : sat_to_acc(direct_wide);

        seed_ok = (measured != '0) && (32'(measured) < ipid_pkg::SEED_LIMIT);

        if (opcode == ipid_pkg::OP_RESTART) begin
            state_nxt.older_temp = '0;
            state_nxt.last_temp  = seed_ok ? measured : '0;
            state_nxt.armed_flag = 1'b0;
            state_nxt.error_sum  = '0;
            state_nxt.power_acc  = '0;
        end else begin
            state_nxt.older_temp = armed_n ? state_cur.last_temp : state_cur.older_temp;
            state_nxt.last_temp  = measured;
            state_nxt.armed_flag = armed_n;
            state_nxt.error_sum  = history ? state_cur.error_sum : sum_sat;
            state_nxt.power_acc  = power_n;
        end

        // Round to nearest, drop the fraction, clamp.
        rnd         = (AB+1)'(state_nxt.power_acc)
                    + $signed((AB+1)'(ipid_pkg::ROUND_HALF));
        shifted     = rnd >>> ipid_pkg::FRACTION_BITS;
        drive_power = sat_to_out(shifted);
    end

endmodule

`default_nettype wire

// ===== src/incremental_pid_temperature_unit.sv =====
// ----------------------------------------------------------------------------
// incremental_pid_temperature_unit: fixed-point temperature PID controller
// Direct form until armed, then velocity form; one result beat per step.
// ----------------------------------------------------------------------------
// Path: a beat waits in the input register until the result register is free;
//   its result is then loaded there and presented on m_.
// Throughput: one beat per cycle while the result side takes its beats; one pass
//   through the step datapath (sum add and clamp, one multiplier level, add and clamp, then round and clamp).
// Reset: aresetn (synchronous, active low) restores default gains, clears
//   the history, accumulators and mode flag, and empties both registers.
`default_nettype none

module incremental_pid_temperature_unit (
    input  wire         aclk,
    input  wire         aresetn,

    // Input channel
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [23:0] s_tdata,   // [9:0] setpoint, [19:10] measured, rest zero
    input  wire  [0:0]  s_tuser,   // [0] opcode

    // Result channel
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [15:0] m_tdata,   // [15:0] drive_power
    output logic [0:0]  m_tuser,   // [0] incremental_mode

    // Gain register writes
    input  wire         cfg_we,
    input  wire  [ipid_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
    input  wire  [ipid_pkg::GAIN_BITS-1:0]     cfg_wdata
);

    localparam int TB = ipid_pkg::TEMP_BITS;

    // Gains
    ipid_pkg::pid_gains_t gains_reg, gains_next;

    // Input register
    logic              in_valid_reg, in_valid_next;
    ipid_pkg::opcode_t in_op_reg, in_op_next;
    ipid_pkg::temp_t   in_set_reg, in_set_next;
    ipid_pkg::temp_t   in_meas_reg, in_meas_next;

    // Controller state
    ipid_pkg::pid_state_t state_reg, state_next, state_step;

    // Result register
    logic             out_valid_reg, out_valid_next;
    ipid_pkg::power_t out_power_reg, out_power_next;
    logic             out_mode_reg, out_mode_next;

    ipid_pkg::power_t step_power;
    logic             s_fire, proc_fire, out_free;

    ipid_step u_step (
        .opcode      (in_op_reg),
        .setpoint    (in_set_reg),
        .measured    (in_meas_reg),
        .gains       (gains_reg),
        .state_cur   (state_reg),
        .state_nxt   (state_step),
        .drive_power (step_power)
    );

    // The result register frees up when empty or when its beat is taken.
    // A restart produces no beat, so it never waits on the result side.
    always_comb begin
        out_free  = !out_valid_reg || m_tready;
        proc_fire = in_valid_reg && ((in_op_reg == ipid_pkg::OP_RESTART) || out_free);
        s_tready  = !in_valid_reg || proc_fire;
        s_fire    = s_tvalid && s_tready;
    end

    // Gain writes
    always_comb begin
        gains_next = gains_reg;
        if (cfg_we) begin
            case (cfg_addr)
                ipid_pkg::REG_GAIN_P: gains_next.gain_p = cfg_wdata;
                ipid_pkg::REG_GAIN_I: gains_next.gain_i = cfg_wdata;
                ipid_pkg::REG_GAIN_D: gains_next.gain_d = cfg_wdata;
                default:              gains_next = gains_reg;
            endcase
        end
    end

    // Input register: load on accept, drop when processed.
    always_comb begin
        in_valid_next = in_valid_reg;
        in_op_next    = in_op_reg;
        in_set_next   = in_set_reg;
        in_meas_next  = in_meas_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
            in_op_next    = ipid_pkg::opcode_t'(s_tuser[0]);
            in_set_next   = s_tdata[TB-1:0];
            in_meas_next  = s_tdata[2*TB-1:TB];
        end else if (proc_fire) begin
            in_valid_next = 1'b0;
        end
    end

    // State advances on every processed beat; the result only on a step beat.
    always_comb begin
        state_next     = proc_fire ? state_step : state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_power_next = out_power_reg;
        out_mode_next  = out_mode_reg;
        if (proc_fire && (in_op_reg == ipid_pkg::OP_STEP)) begin
            out_valid_next = 1'b1;
            out_power_next = step_power;
            out_mode_next  = state_step.armed_flag;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gains_reg.gain_p <= ipid_pkg::GAIN_P_RESET;
            gains_reg.gain_i <= ipid_pkg::GAIN_I_RESET;
            gains_reg.gain_d <= ipid_pkg::GAIN_D_RESET;
            state_reg        <= '0;
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end else begin
            gains_reg     <= gains_next;
            state_reg     <= state_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge aclk) begin
        in_op_reg     <= in_op_next;
        in_set_reg    <= in_set_next;
        in_meas_reg   <= in_meas_next;
        out_power_reg <= out_power_next;
        out_mode_reg  <= out_mode_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_power_reg;
    assign m_tuser  = out_mode_reg;

endmodule

`default_nettype wire
